### rtl/core/sle_pkg.sv
// Shared types and character codes for the serial line editor.
// No dependencies; imported by sle_front, sle_back, sle_checker and both top levels.
`default_nettype none

package sle_pkg;

	localparam int BUFFER_LENGTH_DEF = 32;

	localparam logic [7:0] CH_BEL   = 8'd7;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;

	typedef enum logic [1:0] {
		OP_PRINT,
		OP_ERASE,
		OP_ENTER
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [6:0] ch;
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_CHAR  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/sle_fifo.sv
// Two-entry word queue used between front and back and on the result side.
// Generic payload width; no package dependency.
`default_nettype none

module sle_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);

	logic [W-1:0] ent_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

### rtl/core/sle_front.sv
// Front end: takes received bytes, classifies them into editor commands.
// Depends on sle_pkg; feeds the command queue.
`default_nettype none

module sle_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          push,
	output logic               full,
	output sle_pkg::cmd_t      cmd,
	output logic               cmd_push,
	input  wire logic          cmd_full
);
	import sle_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  cls;
	logic  cls_valid;
	logic  accept;

	always_comb begin
		cls_valid = 1'b1;
		cls.ch    = rx_byte[6:0];
		cls.op    = OP_PRINT;
		unique case (rx_byte) inside
			CH_LF, CH_CR:      cls.op = OP_ENTER;
			CH_BS, CH_DEL:     cls.op = OP_ERASE;
			[CH_SP:CH_TILDE]:  cls.op = OP_PRINT;
			default:           cls_valid = 1'b0;   // other bytes are dropped
		endcase
	end

	assign cmd_push = valid_s1 && !cmd_full;
	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= cls_valid;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cls;
	end

endmodule

`default_nettype wire

### rtl/core/sle_back.sv
// Back end: executes editor commands on the line store and cursor and
// produces result words. Depends on sle_pkg.
`default_nettype none

module sle_back #(
	parameter int BUFFER_LENGTH = sle_pkg::BUFFER_LENGTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sle_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	output sle_pkg::res_t      res,
	output logic               res_push,
	input  wire logic          res_full
);
	import sle_pkg::*;

	localparam int Depth = BUFFER_LENGTH - 1;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW    = $clog2(BUFFER_LENGTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BS_SP,
		ST_BS_BK,
		ST_LF,
		ST_EMPTY,
		ST_LINE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cursor_q;
	logic [CW-1:0]  len_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  idx_nxt;
	logic [CW-1:0]  len_m1;
	logic [6:0]     mem [Depth];
	logic [6:0]     rd_data_q;
	logic [AW-1:0]  rd_addr;
	logic           room;
	logic           mem_we;
	logic           line_last;

	assign room      = (cursor_q < CW'(Depth));
	assign idx_nxt   = idx_q + CW'(1);
	assign len_m1    = len_q - CW'(1);
	assign line_last = (idx_q == len_m1);
	assign mem_we    = cmd_pop && (cmd.op == OP_PRINT) && room;

	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res.kind  = KIND_ECHO;
		res.data  = '0;
		res.last  = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_PRINT: begin
							res_push = 1'b1;
							res.data = room ? {1'b0, cmd.ch} : CH_BEL;
							res.last = 1'b1;
						end
						OP_ERASE: begin
							res_push = (cursor_q != '0);
							res.data = CH_BS;
						end
						OP_ENTER: begin
							res_push = 1'b1;
							res.data = CH_CR;
						end
						default: ;
					endcase
				end
			end
			ST_BS_SP: begin
				res_push = !res_full;
				res.data = CH_SP;
			end
			ST_BS_BK: begin
				res_push = !res_full;
				res.data = CH_BS;
				res.last = 1'b1;
			end
			ST_LF: begin
				res_push = !res_full;
				res.data = CH_LF;
			end
			ST_EMPTY: begin
				res_push = !res_full;
				res.kind = KIND_EMPTY;
				res.last = 1'b1;
			end
			ST_LINE: begin
				res_push = !res_full;
				res.kind = KIND_CHAR;
				res.data = {1'b0, rd_data_q};
				res.last = line_last;
				// prefetch next character while this one goes out
				if (res_push && !line_last)
					rd_addr = idx_nxt[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							OP_PRINT: begin
								if (room)
									cursor_q <= cursor_q + CW'(1);
							end
							OP_ERASE: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - CW'(1);
									state_q  <= ST_BS_SP;
								end
							end
							OP_ENTER: begin
								len_q    <= cursor_q;
								cursor_q <= '0;
								idx_q    <= '0;
								state_q  <= ST_LF;
							end
							default: ;
						endcase
					end
				end
				ST_BS_SP: if (res_push) state_q <= ST_BS_BK;
				ST_BS_BK: if (res_push) state_q <= ST_IDLE;
				ST_LF: begin
					if (res_push)
						state_q <= (len_q == '0) ? ST_EMPTY : ST_LINE;
				end
				ST_EMPTY: if (res_push) state_q <= ST_IDLE;
				ST_LINE: begin
					if (res_push) begin
						if (line_last)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_nxt;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cursor_q[AW-1:0]] <= cmd.ch;
		rd_data_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### rtl/core/serial_line_editor_core.sv
// Serial console line editor: front classifier, 2-word command queue, back
// executor with line store, 2-word result queue.
// Flow: a byte passes the front register, the command queue and the result
// queue before its first result shows; then one result per cycle while pop keeps
// up. Enter emits CR, LF, then the stored chars in order (one empty-line word if
// none are stored), bounded by the one-word-per-cycle result port.
// Reset (arst_n low) empties both queues and clears the cursor; line store
// contents are not cleared.
`default_nettype none

module serial_line_editor_core #(
	parameter int BUFFER_LENGTH = sle_pkg::BUFFER_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic       push,
	output logic            full,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            empty,
	input  wire logic       pop
);
	import sle_pkg::*;

	localparam int CmdW = $bits(cmd_t);
	localparam int ResW = $bits(res_t);

	cmd_t            f_cmd;
	logic            f_cmd_push;
	logic            cq_full;
	logic            cq_empty;
	logic [CmdW-1:0] cq_dout;
	logic            b_cmd_pop;
	res_t            b_res;
	logic            b_res_push;
	logic            rq_full;
	logic [ResW-1:0] rq_dout;
	res_t            res_out;

	sle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.push     (push),
		.full     (full),
		.cmd      (f_cmd),
		.cmd_push (f_cmd_push),
		.cmd_full (cq_full)
	);

	sle_fifo #(.W(CmdW)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_cmd_push),
		.din    (CmdW'(f_cmd)),
		.full   (cq_full),
		.pop    (b_cmd_pop),
		.dout   (cq_dout),
		.empty  (cq_empty)
	);

	sle_back #(.BUFFER_LENGTH(BUFFER_LENGTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_t'(cq_dout)),
		.cmd_empty (cq_empty),
		.cmd_pop   (b_cmd_pop),
		.res       (b_res),
		.res_push  (b_res_push),
		.res_full  (rq_full)
	);

	sle_fifo #(.W(ResW)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_res_push),
		.din    (ResW'(b_res)),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign res_out  = res_t'(rq_dout);
	assign kind     = 2'(res_out.kind);
	assign out_byte = res_out.data;
	assign last     = res_out.last;

endmodule

`default_nettype wire

### tb/sv/sle_checker.sv
// Scoreboard for the serial line editor: follows every accepted input word,
// predicts the echo and line words it causes, and checks each popped word.
// Depends on sle_pkg for the character codes and the result word layout.
module sle_checker #(
	parameter int BUFFER_LENGTH = sle_pkg::BUFFER_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       push,
	input  logic       full,
	input  logic [1:0] kind,
	input  logic [7:0] out_byte,
	input  logic       last,
	input  logic       empty,
	input  logic       pop,
	output int         errors,
	output int         pending
);
	import sle_pkg::*;

	logic [6:0] typed_chars [0:BUFFER_LENGTH-2];
	int         col;
	res_t       due_words [$];

	function automatic void add_word(input kind_t k, input logic [7:0] d, input logic is_last);
		res_t w;
		w.kind = k;
		w.data = d;
		w.last = is_last;
		due_words.push_back(w);
	endfunction

	function automatic void predict_line_edit(input logic [7:0] b);
		int i;
		if (b == CH_CR || b == CH_LF) begin
			add_word(KIND_ECHO, CH_CR, 1'b0);
			add_word(KIND_ECHO, CH_LF, 1'b0);
			if (col == 0) begin
				add_word(KIND_EMPTY, 8'd0, 1'b1);
			end else begin
				for (i = 0; i < col; i++)
					add_word(KIND_CHAR, {1'b0, typed_chars[i]}, i == col - 1);
			end
			col = 0;
		end else if (b >= CH_SP && b <= CH_TILDE) begin
			// printable: stored and echoed if room; line full: ring the bell, nothing stored
			if (col < BUFFER_LENGTH - 1) begin
				typed_chars[col] = b[6:0];
				col++;
				add_word(KIND_ECHO, b, 1'b1);
			end else begin
				add_word(KIND_ECHO, CH_BEL, 1'b1);
			end
		end else if (b == CH_BS || b == CH_DEL) begin
			if (col > 0) begin
				col--;
				add_word(KIND_ECHO, CH_BS, 1'b0);
				add_word(KIND_ECHO, CH_SP, 1'b0);
				add_word(KIND_ECHO, CH_BS, 1'b1);
			end
		end
	endfunction

	// pop side first: a word pushed at this edge cannot have a result yet
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			col = 0;
			errors = 0;
			due_words.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (due_words.size() == 0) begin
					if (errors < 10)
						$display("sle_checker: unexpected word kind=%0d byte=%h last=%b",
							kind, out_byte, last);
					errors++;
				end else begin
					want = due_words.pop_front();
					if (kind !== want.kind || out_byte !== want.data || last !== want.last) begin
						if (errors < 10) begin
							$write("sle_checker: mismatch exp kind=%0d byte=%h last=%b",
								want.kind, want.data, want.last);
							$display(" got kind=%0d byte=%h last=%b", kind, out_byte, last);
						end
						errors++;
					end
				end
			end
			if (push && !full)
				predict_line_edit(rx_byte);
			pending <= due_words.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// Top of the serial line editor bench: clock, reset, typed-line stimulus and
// random pop pressure; sle_checker beside the core does the scoring.
// Depends on sle_pkg, serial_line_editor_core and sle_checker.
module tb_top;
	import sle_pkg::*;

	localparam int ITEMS     = 430;
	localparam int CALM_FROM = 350;
	localparam int HOLD_AT   = 80;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE    = 40;
	localparam int LIMIT     = 1_500_000;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic [7:0] rx_byte = 8'd0;
	logic       push    = 1'b0;
	logic       pop     = 1'b0;
	wire        full;
	wire        empty;
	wire  [1:0] kind;
	wire  [7:0] out_byte;
	wire        last;
	int         errors;
	int         pending;
	int         sent    = 0;
	int         useful  = 0;
	int         cycle_count;
	bit         calm    = 1'b0;

	// extremes, every command, ignored codes, erase on an empty line
	logic [7:0] warmup_bytes [0:19] = '{CH_CR, CH_LF, CH_BS, CH_DEL, 8'h00, CH_BEL, 8'h09,
		8'h1F, 8'h80, 8'hFF, CH_SP, CH_TILDE, 8'h41, 8'h55, CH_BS, CH_DEL, 8'h2A, 8'h7A,
		8'h3F, CH_CR};

	serial_line_editor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.out_byte (out_byte),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

	sle_checker #(.BUFFER_LENGTH(BUFFER_LENGTH_DEF)) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.out_byte (out_byte),
		.last     (last),
		.empty    (empty),
		.pop      (pop),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic send_word(input logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		rx_byte <= b;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
		if (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL || (b >= CH_SP && b <= CH_TILDE))
			useful++;
		calm = useful >= CALM_FROM;
	endtask

	// mostly short lines; some long enough to run into the full-line bell
	task automatic type_line();
		int len;
		int r;
		int k;
		logic [7:0] ch;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 48) : $urandom_range(0, 12);
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				ch = 8'($urandom_range(CH_SP, CH_TILDE));
			else if (r < 95)
				ch = $urandom_range(0, 1) ? CH_BS : CH_DEL;
			else
				ch = 8'($urandom_range(0, 255));
			send_word(ch);
		end
		send_word($urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < 20; i++)
			send_word(warmup_bytes[i]);
		drain_results();
		while (useful < ITEMS) begin
			if ($urandom_range(0, 9) < 8)
				type_line();
			else
				send_word(8'($urandom_range(0, 255)));
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// result side: random pop bursts, plus one long hold so both queues back up
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
			@(posedge clk);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
